/* rtl/core/ucs_pkg.sv */
// ----------------------------------------------------------------------------
// ucs_pkg - shared types, constants and functions for upc_check_and_split
// Widths of the binary and BCD words, conversion depth, digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ucs_pkg;

  localparam int BIN_W       = 40;             // width of the binary code word
  localparam int BCD_DIGITS  = 13;             // twelve code digits plus one overflow digit
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int STEP_BITS   = 4;              // binary bits consumed per conversion stage
  localparam int DD_STAGES   = BIN_W / STEP_BITS;
  localparam int OUT_W       = 48;

  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [3:0]       digit_t;

  // One shift-and-add-3 step: fix up every digit, then shift in the next bit.
  function automatic bcd_t dd_step(input bcd_t bcd, input logic bit_in);
    bcd_t adj;
    adj = bcd;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (adj[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // Digit times ten, as a seven-bit value.
  function automatic logic [6:0] times10(input digit_t d);
    return {d, 3'b000} + {2'b00, d, 1'b0};
  endfunction

  // True when the weighted total is a multiple of ten (total never exceeds 216).
  function automatic logic is_mult10(input logic [7:0] total);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 22; k++) begin
      if (total == 8'(10 * k)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ucs_bcd_stage.sv */
// ----------------------------------------------------------------------------
// ucs_bcd_stage - one stage of the binary-to-BCD conversion pipeline
// Consumes four binary bits per word with shift-and-add-3 and registers
// the partial result together with its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ucs_bcd_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire ucs_pkg::bin_t up_bin,
  input  wire ucs_pkg::bcd_t up_bcd,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output ucs_pkg::bin_t      dn_bin,
  output ucs_pkg::bcd_t      dn_bcd
);
  import ucs_pkg::*;

  logic v_r;
  bin_t bin_r, bin_nxt;
  bcd_t bcd_r, bcd_nxt;

  always_comb begin
    bin_nxt = up_bin;
    bcd_nxt = up_bcd;
    for (int s = 0; s < STEP_BITS; s++) begin
      bcd_nxt = dd_step(bcd_nxt, bin_nxt[BIN_W-1]);
      bin_nxt = {bin_nxt[BIN_W-2:0], 1'b0};
    end
  end

  // take a new word whenever this slot is empty or is being drained
  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_bin   = bin_r;
  assign dn_bcd   = bcd_r;

endmodule

`default_nettype wire

/* rtl/core/upc_check_and_split.sv */
// ----------------------------------------------------------------------------
// upc_check_and_split - UPC-A check digit validation and field split
// Converts a twelve-digit code to decimal, checks the weighted digit total
// and reports company code, product code and check digit.
// ----------------------------------------------------------------------------
// One code word enters per clock and one result word leaves per clock while the
// output is not stalled. There are ten conversion stages (four binary bits
// of shift-and-add-3 each), one stage that pairs digits and sums odd and even
// positions, and the output register that forms the codes and the check bit.
// Each stage holds its own valid bit, so bubbles close up under backpressure.
// Codes above twelve digits are taken modulo 10^12 (the thirteenth decimal
// digit is dropped).
// ----------------------------------------------------------------------------
`default_nettype none

module upc_check_and_split (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [39:0] upc_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [0] code_valid, [20:1] company_code,
                                       // [37:21] product_code, [41:38] check_value,
                                       // [47:42] zero
);
  import ucs_pkg::*;

  logic v     [0:DD_STAGES];
  logic rdy   [0:DD_STAGES];
  bin_t bin_s [0:DD_STAGES];
  bcd_t bcd_s [0:DD_STAGES];

  assign v[0]     = in_tvalid;
  assign bin_s[0] = in_tdata;
  assign bcd_s[0] = '0;
  assign in_tready = rdy[0];

  for (genvar i = 0; i < DD_STAGES; i++) begin : g_dd
    ucs_bcd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[i]),
      .up_ready (rdy[i]),
      .up_bin   (bin_s[i]),
      .up_bcd   (bcd_s[i]),
      .dn_valid (v[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_bin   (bin_s[i+1]),
      .dn_bcd   (bcd_s[i+1])
    );
  end

  // ---- digit stage: pair digits, sum odd and even positions ----
  digit_t d [0:11];
  for (genvar k = 0; k < 12; k++) begin : g_dig
    assign d[k] = bcd_s[DD_STAGES][4*k +: 4];
  end

  logic       va_r;
  logic       ready_a, ready_b;
  logic [6:0] pc0_r, pc1_r, pc2_r, pp0_r, pp1_r;
  logic [6:0] pc0_nxt, pc1_nxt, pc2_nxt, pp0_nxt, pp1_nxt;
  digit_t     pd1_r, chk_r;
  logic [5:0] odd_r, even_r, odd_nxt, even_nxt;

  always_comb begin
    pc0_nxt  = times10(d[11]) + {3'b000, d[10]};
    pc1_nxt  = times10(d[9])  + {3'b000, d[8]};
    pc2_nxt  = times10(d[7])  + {3'b000, d[6]};
    pp0_nxt  = times10(d[5])  + {3'b000, d[4]};
    pp1_nxt  = times10(d[3])  + {3'b000, d[2]};
    // d[11] is the first digit from the left; d[0] is the check digit
    odd_nxt  = 6'(d[11]) + 6'(d[9]) + 6'(d[7]) + 6'(d[5]) + 6'(d[3]) + 6'(d[1]);
    even_nxt = 6'(d[10]) + 6'(d[8]) + 6'(d[6]) + 6'(d[4]) + 6'(d[2]) + 6'(d[0]);
  end

  assign rdy[DD_STAGES] = ready_a;
  assign ready_a = !va_r || ready_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (ready_a) begin
      va_r <= v[DD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (v[DD_STAGES] && ready_a) begin
      pc0_r  <= pc0_nxt;
      pc1_r  <= pc1_nxt;
      pc2_r  <= pc2_nxt;
      pp0_r  <= pp0_nxt;
      pp1_r  <= pp1_nxt;
      pd1_r  <= d[1];
      chk_r  <= d[0];
      odd_r  <= odd_nxt;
      even_r <= even_nxt;
    end
  end

  // ---- output register ----
  logic        out_valid_r;
  logic        code_ok_r, code_ok_nxt;
  logic [19:0] company_r, company_nxt;
  logic [16:0] product_r, product_nxt;
  digit_t      check_r;
  logic [7:0]  total;

  always_comb begin
    total       = 8'(odd_r) + 8'({odd_r, 1'b0}) + 8'(even_r);
    code_ok_nxt = is_mult10(total);
    company_nxt = 20'(pc0_r) * 20'd10000 + 20'(pc1_r) * 20'd100 + 20'(pc2_r);
    product_nxt = 17'(pp0_r) * 17'd1000 + 17'(pp1_r) * 17'd10 + 17'(pd1_r);
  end

  assign ready_b = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_b) begin
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r && ready_b) begin
      code_ok_r <= code_ok_nxt;
      company_r <= company_nxt;
      product_r <= product_nxt;
      check_r   <= chk_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, check_r, product_r, company_r, code_ok_r};

  // ---- assertions ----
  a_check_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[41:38] <= 4'd9)
    else $error("check digit is not a decimal digit");

  a_company_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:1] <= 20'd999999)
    else $error("company code out of range");

  a_product_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:21] <= 17'd99999)
    else $error("product code out of range");

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - stream-level check of upc_check_and_split
// Drives twelve-digit codes and random 40-bit words into the block with random
// idle gaps and output stalls. A scoreboard predicts the validity bit,
// company code, product code and check digit of every accepted word, and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import ucs_pkg::*;

  localparam longint unsigned UPC_MOD     = 64'd1000000000000;
  localparam longint unsigned BODY_MOD    = 64'd100000000000;
  localparam longint unsigned PROD_SCALE  = 64'd100000;
  localparam int              CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3:0]  check_value;
    logic [16:0] product_code;
    logic [19:0] company_code;
    logic        code_valid;
  } upc_split_t;

  class upc_split_board;
    upc_split_t  pending_splits[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Weighted total: odd positions (from the left) times three, plus the
    // even positions and the check digit.
    static function int unsigned weighted_total(longint unsigned code);
      longint unsigned rest;
      int unsigned     odd_sum;
      int unsigned     flat_sum;
      rest     = code / 10;
      odd_sum  = 0;
      flat_sum = 0;
      for (int pos = 1; pos < 12; pos++) begin
        if (pos % 2 == 1) begin
          odd_sum += int'(rest % 10);
        end else begin
          flat_sum += int'(rest % 10);
        end
        rest = rest / 10;
      end
      return odd_sum * 3 + flat_sum + int'(code % 10);
    endfunction

    static function upc_split_t split_upc(bin_t raw);
      upc_split_t      s;
      longint unsigned code;
      longint unsigned body;
      code           = longint'(raw) % UPC_MOD;
      body           = code / 10;
      s.code_valid   = (weighted_total(code) % 10 == 0);
      s.company_code = 20'(body / PROD_SCALE);
      s.product_code = 17'(body % PROD_SCALE);
      s.check_value  = 4'(code % 10);
      return s;
    endfunction

    function void note_code(bin_t raw);
      pending_splits.push_back(split_upc(raw));
    endfunction

    function void check_word(logic [OUT_W-1:0] word);
      upc_split_t want;
      upc_split_t got;
      if (pending_splits.size() == 0) begin
        $error("result word %h with no code pending", word);
        mismatches++;
        return;
      end
      want = pending_splits.pop_front();
      got  = upc_split_t'(word[41:0]);
      if (got.code_valid !== want.code_valid) begin
        $error("code_valid: expected %0d, got %0d", want.code_valid, got.code_valid);
        mismatches++;
      end
      if (got.company_code !== want.company_code) begin
        $error("company_code: expected %0d, got %0d", want.company_code,
               got.company_code);
        mismatches++;
      end
      if (got.product_code !== want.product_code) begin
        $error("product_code: expected %0d, got %0d", want.product_code,
               got.product_code);
        mismatches++;
      end
      if (got.check_value !== want.check_value) begin
        $error("check_value: expected %0d, got %0d", want.check_value, got.check_value);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  bin_t             in_tdata   = '0;   // [39:0] upc_value
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // [0] code_valid, [20:1] company_code,
                                       // [37:21] product_code, [41:38] check_value

  upc_split_board board = new();
  int             cycle_count = 0;
  int             stall_left  = 0;
  bit             sink_quiet  = 1'b0;
  bit             src_quiet   = 1'b0;

  upc_check_and_split u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and quiet stretches with none.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Result side: take a word when present, then stall at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_word(out_tdata);
    end
    if ($urandom_range(0, 99) < 3) begin
      sink_quiet = !sink_quiet;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap(sink_quiet);
    end
  end

  task automatic send_code(bin_t raw);
    int gap;
    if ($urandom_range(0, 99) < 3) begin
      src_quiet = !src_quiet;
    end
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_code(raw);
  endtask

  task automatic drain_results();
    while (board.pending_splits.size() != 0) @(posedge clk);
  endtask

  function automatic bin_t any_word();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  // Well-formed code: random first eleven digits, check digit made to fit.
  function automatic bin_t valid_code();
    longint unsigned body;
    int unsigned     t;
    body = longint'(any_word()) % BODY_MOD;
    t    = upc_split_board::weighted_total(body * 10);
    return bin_t'(body * 10 + (10 - t % 10) % 10);
  endfunction

  initial begin
    bin_t directed[$];
    int   pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      40'd0, 40'd1, 40'd9, 40'd10, 40'd36000291452, 40'd36000291453,
      40'd12345678905, 40'd999999999999, 40'd999999999990, 40'd999999999994,
      40'd1000000000000, 40'd1000000000001, 40'hFFFFFFFFFF, 40'hAAAAAAAAAA,
      40'h5555555555, 40'h8000000000, 40'd909090909090, 40'd90909090909,
      40'd100000000000, 40'd99999, 40'd100000, 40'd999999999995
    };
    foreach (directed[i]) begin
      send_code(directed[i]);
    end

    for (int n = 0; n < 900; n++) begin
      if (n == 450) begin
        // hold off until the pipeline has emptied
        in_tvalid <= 1'b0;
        @(posedge clk);
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_code(valid_code());
      end else if (pick < 75) begin
        send_code(bin_t'(longint'(any_word()) % UPC_MOD));
      end else begin
        send_code(any_word());
      end
    end
    in_tvalid <= 1'b0;

    drain_results();
    repeat (30) @(posedge clk);
    if (board.mismatches == 0 && board.pending_splits.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ucs_pkg.sv
rtl/core/ucs_bcd_stage.sv
rtl/core/upc_check_and_split.sv
dv/testbench.sv
